### src/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 block hash.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned CHAIN_WORDS = 5;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUND_W     = 7;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned IDX_W       = 3;

  localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
  localparam logic [POS_W-1:0]   LAST_POS   = 4'd15;
  localparam logic [IDX_W-1:0]   LAST_IDX   = 3'd4;

  localparam word_t H0 = 32'h6745_2301;
  localparam word_t H1 = 32'hEFCD_AB89;
  localparam word_t H2 = 32'h98BA_DCFE;
  localparam word_t H3 = 32'h1032_5476;
  localparam word_t H4 = 32'hC3D2_E1F0;

  localparam word_t K0 = 32'h5A82_7999;
  localparam word_t K1 = 32'h6ED9_EBA1;
  localparam word_t K2 = 32'h8F1B_BCDC;
  localparam word_t K3 = 32'hCA62_C1D6;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic init_chain;  // reload initial chaining values
    logic load_word;   // shift an input word into the window
    logic start;       // copy chaining words into a..e
    logic round_en;    // run one round
    logic finish;      // add a..e into the chaining words
  } sha1_ctrl_t;

endpackage

### src/sha1_if.sv
// ----------------------------------------------------------------------------
// sha1_if
// Valid/ready channels for message words in and digest words out.
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic        first_word;
  logic        last_word;

  modport source (output valid, message_word, first_word, last_word, input ready);
  modport sink   (input valid, message_word, first_word, last_word, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;

  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

### src/sha1_sched.sv
// ----------------------------------------------------------------------------
// sha1_sched
// Sixteen-word message schedule window as a shift line; emits W[t].
// ----------------------------------------------------------------------------
module sha1_sched (
  input  logic                        clk,
  input  sha1_pkg::sha1_ctrl_t        ctrl,
  input  sha1_pkg::word_t             word_in,
  input  logic [sha1_pkg::ROUND_W-1:0] round_idx,
  output sha1_pkg::word_t             w
);
  import sha1_pkg::*;

  word_t win [BLOCK_WORDS];
  word_t mix;
  word_t w_exp;

  // win[0] is the oldest word: W[t] for t<16, W[t-16] afterwards.
  assign mix   = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w_exp = {mix[30:0], mix[31]};
  assign w     = (round_idx < ROUND_W'(BLOCK_WORDS)) ? win[0] : w_exp;

  always_ff @(posedge clk) begin
    if (ctrl.load_word || ctrl.round_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[BLOCK_WORDS-1] <= ctrl.load_word ? word_in : w;
    end
  end

endmodule

### src/sha1_round.sv
// ----------------------------------------------------------------------------
// sha1_round
// Chaining words, working words a..e and the shared round unit.
// ----------------------------------------------------------------------------
module sha1_round (
  input  logic                         clk,
  input  logic                         rst,
  input  sha1_pkg::sha1_ctrl_t         ctrl,
  input  sha1_pkg::word_t              w,
  input  logic [sha1_pkg::ROUND_W-1:0] round_idx,
  input  logic [sha1_pkg::IDX_W-1:0]   chain_sel,
  output sha1_pkg::word_t              chain_word
);
  import sha1_pkg::*;

  word_t chain [CHAIN_WORDS];
  word_t a, b, c, d, e;
  word_t f, k, tmp;

  always_comb begin
    priority if (round_idx < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round_idx < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round_idx < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + k + w;

  always_comb begin
    unique case (chain_sel)
      3'd0:    chain_word = chain[0];
      3'd1:    chain_word = chain[1];
      3'd2:    chain_word = chain[2];
      3'd3:    chain_word = chain[3];
      3'd4:    chain_word = chain[4];
      default: chain_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init_chain) begin
      chain[0] <= H0;
      chain[1] <= H1;
      chain[2] <= H2;
      chain[3] <= H3;
      chain[4] <= H4;
    end else if (ctrl.finish) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (ctrl.round_en) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= tmp;
    end
  end

endmodule

### src/sha1_block_hash.sv
// ----------------------------------------------------------------------------
// sha1_block_hash
// SHA-1 over an already padded message, one round per clock.
// ----------------------------------------------------------------------------
// Usage:
//   msg    : one beat per 32-bit big-endian message word, 16 words a block.
//            first_word on a beat restarts at word 0 with the initial
//            chaining values; last_word counts only on a block's 16th word.
//   digest : five beats, H0 first, digest_index 0..4, digest_last on the
//            fifth beat.
// Timing:
//   Words 1..15 of a block are taken as they come. The 16th word starts the
//   compression: rounds through the single round adder, then the chaining
//   add, with msg.ready low throughout both. With last_word the digest
//   follows right after the chaining add, one beat per cycle while
//   digest.ready is high.
// Reset: back to idle, word position 0, initial chaining values loaded.
// Stalls: msg.ready stays low while rounds run and while digest beats are
//   pending; a stalled digest beat holds until taken.
// ----------------------------------------------------------------------------
module sha1_block_hash (
  input  logic       clk,
  input  logic       rst,
  sha1_in_if.sink    msg,
  sha1_out_if.source digest
);
  import sha1_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]         state;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_eff;
  logic [ROUND_W-1:0] round_cnt;
  logic [IDX_W-1:0]   emit_idx;
  logic               last_flag;
  logic               msg_beat;
  logic               dig_beat;
  sha1_ctrl_t         ctrl;
  word_t              w;
  word_t              chain_word;

  assign msg.ready = (state == ST_IDLE);
  assign msg_beat  = msg.valid && msg.ready;
  assign dig_beat  = digest.valid && digest.ready;

  // first_word restarts the block before this word lands
  assign pos_eff = msg.first_word ? '0 : pos;

  always_comb begin
    ctrl.init_chain = msg_beat && msg.first_word;
    ctrl.load_word  = msg_beat;
    ctrl.start      = msg_beat && (pos_eff == LAST_POS);
    ctrl.round_en   = (state == ST_ROUND);
    ctrl.finish     = (state == ST_FINAL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      round_cnt <= '0;
      emit_idx  <= '0;
      last_flag <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (msg_beat) begin
            pos <= pos_eff + 1'b1;
            if (pos_eff == LAST_POS) begin
              state     <= ST_ROUND;
              last_flag <= msg.last_word;
            end
          end
        end
        ST_ROUND: begin
          if (round_cnt == LAST_ROUND) begin
            round_cnt <= '0;
            state     <= ST_FINAL;
          end else begin
            round_cnt <= round_cnt + 1'b1;
          end
        end
        ST_FINAL: begin
          emit_idx <= '0;
          state    <= last_flag ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (dig_beat) begin
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == LAST_IDX) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  sha1_sched u_sched (
    .clk       (clk),
    .ctrl      (ctrl),
    .word_in   (msg.message_word),
    .round_idx (round_cnt),
    .w         (w)
  );

  sha1_round u_round (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .w          (w),
    .round_idx  (round_cnt),
    .chain_sel  (emit_idx),
    .chain_word (chain_word)
  );

  // Digest beats come straight from the chaining registers.
  assign digest.valid        = (state == ST_EMIT);
  assign digest.digest_word  = chain_word;
  assign digest.digest_index = emit_idx;
  assign digest.digest_last  = (emit_idx == LAST_IDX);

endmodule

### src/sha1_block_hash_chk.sv
// ----------------------------------------------------------------------------
// sha1_block_hash_chk
// Port-level checks on the SHA-1 block hash, bound to the top level.
// ----------------------------------------------------------------------------
module sha1_block_hash_chk (
  input logic       clk,
  input logic       rst,
  input logic       msg_ready,
  input logic       dig_valid,
  input logic       dig_ready,
  input logic [2:0] dig_index,
  input logic       dig_last
);

  // no new word is taken while a digest is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(dig_valid && msg_ready))
    else $error("msg ready while digest pending");

  a_last_on_fifth: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (dig_last == (dig_index == 3'd4)))
    else $error("digest_last not on fifth word");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_ready && !dig_last) |=>
      (dig_valid && dig_index == $past(dig_index) + 3'd1))
    else $error("digest words not contiguous");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_ready && dig_last) |=> !dig_valid)
    else $error("extra digest word after last");

endmodule

bind sha1_block_hash sha1_block_hash_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .msg_ready (msg.ready),
  .dig_valid (digest.valid),
  .dig_ready (digest.ready),
  .dig_index (digest.digest_index),
  .dig_last  (digest.digest_last)
);

### tb/sv/sha1_block_hash_test.sv
// ----------------------------------------------------------------------------
// sha1_block_hash_test
// Self-checking bench for the SHA-1 block hash. Message words go in through
// the msg channel under random bursts and gaps. Digest beats are taken under a
// changing stall pattern and compared field by field with a behavioral SHA-1
// predictor that follows every accepted word.
// ----------------------------------------------------------------------------
module sha1_block_hash_test;
  import sha1_pkg::*;

  // One message beat as driven on msg.
  typedef struct {
    word_t word;
    logic  first;
    logic  last;
  } msg_beat_t;

  // One digest beat as expected on digest.
  typedef struct {
    word_t          word;
    logic [IDX_W-1:0] index;
    logic           last;
  } digest_beat_t;

  logic clk;
  logic rst = 1'b1;

  sha1_in_if  msg ();
  sha1_out_if digest ();

  sha1_block_hash u_top (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .digest (digest)
  );

  // --------------------------------------------------------------------------
  // Directed rows. Nothing here is typed in as an expected value: every row
  // feeds the predictor, which queues the digest beats it implies.
  // --------------------------------------------------------------------------
  localparam int DIRECTED_ROWS = 25;

  msg_beat_t directed_rows [DIRECTED_ROWS] = '{
    // partial block with extreme words; last mark on word 2 is early -> ignored
    '{32'hFFFF_FFFF, 1'b1, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b1},
    '{32'h0000_0001, 1'b0, 1'b0},
    '{32'hA5A5_A5A5, 1'b0, 1'b0},
    // restart mid-block: padded "abc", one block, last on word 15 -> digest
    '{32'h6162_6380, 1'b1, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0018, 1'b0, 1'b1},
    // no first_word: keeps chaining from the digest just emitted
    '{32'hFFFF_FFFF, 1'b0, 1'b1},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'h1234_5678, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0}
  };

  // --------------------------------------------------------------------------
  // SHA-1 predictor state, updated at every accepted msg beat.
  // --------------------------------------------------------------------------
  word_t            chain_h   [CHAIN_WORDS];
  word_t            sched_win [BLOCK_WORDS];
  logic [POS_W-1:0] next_pos;

  digest_beat_t pending_digest [$];  // digest beats still owed by the block
  int           err_count;
  int           burst_left;

  function automatic word_t rol(input word_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic load_initial_chain;
    chain_h[0] = H0;
    chain_h[1] = H1;
    chain_h[2] = H2;
    chain_h[3] = H3;
    chain_h[4] = H4;
  endtask

  // 80 rounds over the window, then fold a..e into the chaining words.
  task automatic compress_window;
    word_t a, b, c, d, e, f, k, w, tmp;
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        w = sched_win[t];
      end else begin
        w = rol(sched_win[(t - 3) & 15] ^ sched_win[(t - 8) & 15] ^
                sched_win[(t - 14) & 15] ^ sched_win[t & 15], 1);
        sched_win[t & 15] = w;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      tmp = rol(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = tmp;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endtask

  // Track one accepted word; queue five digest beats when a message closes.
  task automatic predict_word(input word_t w, input logic first, input logic last);
    digest_beat_t beat;
    if (first) begin
      load_initial_chain();
      next_pos = '0;
    end
    sched_win[next_pos] = w;
    if (next_pos == LAST_POS) begin
      compress_window();
      // a last mark anywhere but the 16th word is dropped
      if (last) begin
        for (int i = 0; i < CHAIN_WORDS; i++) begin
          beat.word  = chain_h[i];
          beat.index = IDX_W'(i);
          beat.last  = (beat.index == LAST_IDX);
          pending_digest.push_back(beat);
        end
      end
    end
    next_pos = next_pos + 1'b1;
  endtask

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Sender. Bursts of back-to-back beats with random gaps between them.
  // valid gets at most one nonblocking write per time step.
  // --------------------------------------------------------------------------
  task automatic send_beat(input word_t w, input logic first, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        msg.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    burst_left--;
    msg.valid        <= 1'b1;
    msg.message_word <= w;
    msg.first_word   <= first;
    msg.last_word    <= last;
    do @(posedge clk); while (!msg.ready);
    predict_word(w, first, last);
  endtask

  // Hold off until every owed digest beat has been taken.
  task automatic wait_for_digests;
    msg.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_digest.size() != 0);
  endtask

  // Mostly random words, with the all-zero and all-one extremes mixed in.
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock and the single reset.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed rows, one forced drain, then random messages.
  // --------------------------------------------------------------------------
  initial begin
    int    rand_beats;
    int    messages;
    int    n;
    int    nblk;
    logic  fresh;

    msg.valid        <= 1'b0;
    msg.message_word <= '0;
    msg.first_word   <= 1'b0;
    msg.last_word    <= 1'b0;
    err_count  = 0;
    burst_left = 0;
    rand_beats = 0;
    messages   = 0;
    load_initial_chain();
    foreach (sched_win[i]) sched_win[i] = '0;
    next_pos = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].word, directed_rows[i].first, directed_rows[i].last);

    // pressure point: nothing new until the directed digest is out
    wait_for_digests();

    // Mostly well-formed messages with random content; about one in five is a
    // restart that gets abandoned before its 16th word.
    while (rand_beats < 100 || messages < 3) begin
      if ($urandom_range(0, 5) == 0)
        wait_for_digests();
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 15);
        for (int i = 0; i < n; i++)
          send_beat(rand_word(), i == 0, $urandom_range(0, 3) == 0);
        rand_beats += n;
      end else begin
        // a message without first_word picks up wherever the block stands
        fresh = ($urandom_range(0, 5) != 0);
        nblk  = ($urandom_range(0, 4) == 0) ? 2 : 1;
        n     = (fresh ? 16 : 16 - int'(next_pos)) + 16 * (nblk - 1);
        for (int i = 0; i < n; i++)
          send_beat(rand_word(), fresh && i == 0,
                    (i == n - 1) ? 1'b1 : ($urandom_range(0, 11) == 0));
        rand_beats += n;
        messages++;
      end
    end

    wait_for_digests();
    // a spurious digest would show within a compression or so
    repeat (120) @(posedge clk);
    if (err_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern: keep switching between randomly chosen modes - always ready,
  // coin flip, mostly stalled, or a long stall with a rare opening.
  // --------------------------------------------------------------------------
  initial begin
    int mode;
    int cyc;
    mode = 0;
    cyc  = 0;
    digest.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cyc % 40 == 0)
        mode = $urandom_range(0, 3);
      cyc++;
      case (mode)
        0:       digest.ready <= 1'b1;
        1:       digest.ready <= ($urandom_range(0, 1) == 1);
        2:       digest.ready <= ($urandom_range(0, 3) == 0);
        default: digest.ready <= (cyc % 16 == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Digest checker: every taken beat against the oldest owed beat.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst && digest.valid && digest.ready) begin
      if (pending_digest.size() == 0) begin
        report_mismatch("unexpected digest beat", digest.digest_word, '0);
      end else begin
        want = pending_digest.pop_front();
        if (digest.digest_word !== want.word)
          report_mismatch("digest_word", digest.digest_word, want.word);
        if (digest.digest_index !== want.index)
          report_mismatch("digest_index", 32'(digest.digest_index), 32'(want.index));
        if (digest.digest_last !== want.last)
          report_mismatch("digest_last", 32'(digest.digest_last), 32'(want.last));
      end
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_400_000;
    $display("status: fail");
    $finish;
  end

endmodule
